### rtl/xrg_pkg.sv
package xrg_pkg;
  localparam int W = 64;
  localparam logic [W-1:0] GOLDEN = 64'h9E3779B97F4A7C15;
  localparam logic [W-1:0] MIX_A = 64'hff51afd7ed558ccd;
  localparam logic [W-1:0] MIX_B = 64'hc4ceb9fe1a85ec53;
  localparam logic [W-1:0] BIAS = 64'h8000000000000000;

  typedef enum logic [1:0] {
    OP_RESEED = 2'd0,
    OP_RAW64  = 2'd1,
    OP_HI32   = 2'd2,
    OP_RANGE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FOLD,
    ST_MIX,
    ST_FILL,
    ST_WARM,
    ST_DRAW,
    ST_MOD,
    ST_OUT
  } state_t;

  // multiplier control: start one serial product, done pulse
  typedef struct packed {
    logic start;
    logic [W-1:0] a;
    logic [W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [W-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic start;
    logic [W-1:0] num;
    logic [W-1:0] den;
  } mod_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [W-1:0] rotl(input logic [W-1:0] x, input int k);
    rotl = (x << k) | (x >> (W - k));
  endfunction
endpackage

### rtl/xrg_if.sv
interface xrg_in_if;
  import xrg_pkg::*;
  logic valid;
  logic ready;
  logic [1:0] op;
  logic signed [63:0] range_min;
  logic signed [63:0] range_max;
  modport source (output valid, op, range_min, range_max, input ready);
  modport sink (input valid, op, range_min, range_max, output ready);
endinterface

interface xrg_out_if;
  logic valid;
  logic ready;
  logic [63:0] value;
  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

### rtl/xrg_mul.sv
// shift-add multiplier, one bit of b per cycle, low 64 bits of product
module xrg_mul import xrg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);
  logic [W-1:0] a_sh;
  logic [W-1:0] b_sh;
  logic [W-1:0] acc;
  logic [6:0] cnt;
  logic busy;
  logic done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt <= 7'd0;
        a_sh <= req.a;
        b_sh <= req.b;
        acc <= '0;
      end else if (busy) begin
        if (b_sh[0]) acc <= acc + a_sh;
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt <= cnt + 7'd1;
        if (cnt == 7'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.p = acc;

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("mul done while busy");
  assert property (@(posedge clk) disable iff (rst) (req.start && !busy) |=> busy)
    else $error("mul did not start");
  assert property (@(posedge clk) disable iff (rst) busy && cnt != 7'(W - 1) |=> busy)
    else $error("mul ended early");
endmodule

### rtl/xrg_mod.sv
// restoring remainder, one numerator bit per cycle
module xrg_mod import xrg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);
  logic [W-1:0] num;
  logic [W-1:0] den;
  logic [W-1:0] rem;
  logic [6:0] cnt;
  logic busy;
  logic done;
  logic [W:0] trial;

  assign trial = {rem, num[W-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt <= '0;
        num <= req.num;
        den <= req.den;
        rem <= '0;
      end else if (busy) begin
        if (!trial[W]) rem <= trial[W-1:0];
        else rem <= {rem[W-2:0], num[W-1]};
        num <= num << 1;
        cnt <= cnt + 7'd1;
        if (cnt == 7'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.rem = rem;

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("mod done while busy");
  assert property (@(posedge clk) disable iff (rst) (req.start && !busy) |=> busy)
    else $error("mod did not start");
  assert property (@(posedge clk) disable iff (rst) busy && cnt != 7'(W - 1) |=> busy)
    else $error("mod ended early");
endmodule

### rtl/xoshiro256ss_random_generator.sv
// channel | dir | payload
// in      | in  | op, range_min, range_max
// out     | out | value
// cfg     | in  | seed_value_we, seed_value
// raw draw: ST_DRAW then ST_OUT; range draw adds ST_MOD (serial remainder) unless span is zero
// reseed: fold 8 serial multiplies plus 8 mix multiplies
// rst clears state words to zero (unseeded) and the seed register
// the output register holds a result while out.ready is low; no new
// transaction is taken until the result is gone
module xoshiro256ss_random_generator import xrg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         seed_value_we,
  input  logic [63:0]  seed_value,
  xrg_in_if.sink       in,
  xrg_out_if.source    out
);
  state_t state, state_next;
  logic [W-1:0] seed;
  logic [W-1:0] s0, s1, s2, s3;
  logic [1:0] op;
  logic [W-1:0] lo, hi;
  logic [W-1:0] acc;
  logic [3:0] step;
  logic [2:0] phase;
  logic [W-1:0] x;
  logic [W-1:0] res;
  logic res_valid;
  mul_req_t mreq;
  mul_rsp_t mrsp;
  mod_req_t dreq;
  mod_rsp_t drsp;
  logic [W-1:0] span;
  logic [W-1:0] xs;
  logic zero_state;

  xrg_mul u_mul (.clk, .rst, .req(mreq), .rsp(mrsp));
  xrg_mod u_mod (.clk, .rst, .req(dreq), .rsp(drsp));

  assign zero_state = ((s0 | s1 | s2 | s3) == '0);
  assign span = hi - lo + 64'd1;
  assign in.ready = (state == ST_IDLE) && !res_valid;
  assign out.valid = res_valid;
  assign out.value = res;
  // output of advance: rotl(s1*5,7)*9 via shifts and adds
  assign xs = rotl(s1 + (s1 << 2), 7);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in.valid && in.ready) begin
        if (in.op == OP_RESEED || zero_state) state_next = ST_FOLD;
        else state_next = ST_DRAW;
      end
      ST_FOLD: if (mrsp.done && step == 4'd7) state_next = ST_MIX;
      ST_MIX:  if (mrsp.done && phase == 3'd1) state_next = ST_FILL;
      ST_FILL: state_next = (step == 4'd3) ? ST_WARM : ST_MIX;
      ST_WARM: if (step == 4'd7) state_next = (op == OP_RESEED) ? ST_OUT : ST_DRAW;
      ST_DRAW: state_next = (op == OP_RANGE && span != '0) ? ST_MOD : ST_OUT;
      ST_MOD:  if (drsp.done) state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mreq = '0;
    dreq = '0;
    case (state)
      ST_FOLD: begin
        mreq.start = !mrsp.busy && !mrsp.done;
        mreq.a = acc;
        mreq.b = GOLDEN;
      end
      ST_MIX: begin
        mreq.start = !mrsp.busy && !mrsp.done;
        mreq.a = acc ^ (acc >> 33);
        mreq.b = (phase == 3'd0) ? MIX_A : MIX_B;
      end
      ST_MOD: begin
        dreq.start = !drsp.busy && !drsp.done;
        dreq.num = x;
        dreq.den = span;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      seed <= '0;
      s0 <= '0; s1 <= '0; s2 <= '0; s3 <= '0;
      res_valid <= 1'b0;
      step <= '0;
      phase <= '0;
    end else begin
      state <= state_next;
      if (seed_value_we) seed <= seed_value;
      if (res_valid && out.ready) res_valid <= 1'b0;
      case (state)
        ST_IDLE: if (in.valid && in.ready) begin
          op <= in.op;
          if ((in.range_min ^ BIAS) > (in.range_max ^ BIAS)) begin
            lo <= in.range_max; hi <= in.range_min;
          end else begin
            lo <= in.range_min; hi <= in.range_max;
          end
          acc <= GOLDEN;
          step <= '0;
          phase <= '0;
        end
        ST_FOLD: if (mrsp.done) begin
          acc <= mrsp.p + {56'd0, seed[8*step[2:0] +: 8]};
          step <= step + 4'd1;
          if (step == 4'd7) step <= '0;
        end
        ST_MIX: if (mrsp.done) begin
          acc <= mrsp.p;
          phase <= phase + 3'd1;
        end
        ST_FILL: begin
          case (step[1:0])
            2'd0: s0 <= (acc ^ (acc >> 33));
            2'd1: s1 <= (acc ^ (acc >> 33)) + GOLDEN;
            2'd2: s2 <= (acc ^ (acc >> 33)) + (GOLDEN << 1);
            default: s3 <= (acc ^ (acc >> 33)) + (GOLDEN + (GOLDEN << 1));
          endcase
          acc <= acc ^ (acc >> 33);
          phase <= '0;
          step <= (step == 4'd3) ? 4'd0 : step + 4'd1;
        end
        ST_WARM, ST_DRAW: begin
          s2 <= s2 ^ s0 ^ (s1 << 17);
          s3 <= rotl(s3 ^ s1, 45);
          s1 <= s1 ^ s2 ^ s0;
          s0 <= s0 ^ s3 ^ s1;
          step <= step + 4'd1;
          if (state == ST_DRAW) begin
            x <= xs + (xs << 3);
            res <= xs + (xs << 3);
          end
        end
        ST_MOD: if (drsp.done) res <= lo + drsp.rem;
        ST_OUT: begin
          case (op)
            OP_RESEED: res <= '0;
            OP_HI32: res <= {32'd0, x[63:32]};
            default: ;
          endcase
          res_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) in.valid && in.ready |-> !res_valid)
    else $error("accepted while result pending");
  assert property (@(posedge clk) disable iff (rst) state == ST_OUT |=> res_valid)
    else $error("result not posted");
  assert property (@(posedge clk) disable iff (rst) state == ST_DRAW |=> !zero_state)
    else $error("draw left zero state");
endmodule

### test/tb_xoshiro256ss_random_generator.sv
module tb_xoshiro256ss_random_generator;
  import xrg_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 4000000;
  localparam logic [63:0] S64_MIN = 64'h8000000000000000;
  localparam logic [63:0] S64_MAX = 64'h7fffffffffffffff;

  logic clk;
  logic rst;
  logic seed_value_we;
  logic [63:0] seed_value;

  xrg_in_if in_ch();
  xrg_out_if out_ch();

  xoshiro256ss_random_generator uut (
    .clk(clk),
    .rst(rst),
    .seed_value_we(seed_value_we),
    .seed_value(seed_value),
    .in(in_ch.sink),
    .out(out_ch.source)
  );

  logic [63:0] gen_words [4];
  logic [63:0] seed_reg;
  logic [63:0] expected_values [$];
  int errors = 0;
  longint unsigned cycles = 0;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] rotl64(logic [63:0] x, int k);
    return (x << k) | (x >> (64 - k));
  endfunction

  function automatic logic [63:0] step_words();
    logic [63:0] r;
    logic [63:0] t;
    r = rotl64(gen_words[1] * 64'd5, 7) * 64'd9;
    t = gen_words[1] << 17;
    gen_words[2] ^= gen_words[0];
    gen_words[3] ^= gen_words[1];
    gen_words[1] ^= gen_words[2];
    gen_words[0] ^= gen_words[3];
    gen_words[2] ^= t;
    gen_words[3] = rotl64(gen_words[3], 45);
    return r;
  endfunction

  function automatic void seed_words(logic [63:0] s);
    logic [63:0] acc;
    logic [63:0] junk;
    acc = GOLDEN;
    for (int i = 0; i < 8; i++) acc = acc * GOLDEN + {56'd0, s[8*i +: 8]};
    for (int i = 0; i < 4; i++) begin
      acc ^= acc >> 33;
      acc *= MIX_A;
      acc ^= acc >> 33;
      acc *= MIX_B;
      acc ^= acc >> 33;
      gen_words[i] = acc + 64'(i) * GOLDEN;
    end
    for (int i = 0; i < 8; i++) junk = step_words();
  endfunction

  function automatic logic [63:0] draw_word();
    if ((gen_words[0] | gen_words[1] | gen_words[2] | gen_words[3]) == 64'd0)
      seed_words(seed_reg);
    return step_words();
  endfunction

  function automatic logic [63:0] predict_value(op_t op, logic [63:0] lo, logic [63:0] hi);
    logic [63:0] t;
    logic [63:0] span;
    logic [63:0] x;
    case (op)
      OP_RESEED: begin
        seed_words(seed_reg);
        return 64'd0;
      end
      OP_RAW64: return draw_word();
      OP_HI32: return draw_word() >> 32;
      default: begin
        if ($signed(lo) > $signed(hi)) begin
          t = lo;
          lo = hi;
          hi = t;
        end
        span = hi - lo + 64'd1;
        x = draw_word();
        if (span == 64'd0) return x;
        return lo + (x % span);
      end
    endcase
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_values.size() == 0) begin
        $display("%0t: unexpected transaction, value %h", $time, out_ch.value);
        errors++;
      end else begin
        if (out_ch.value !== expected_values[0]) begin
          $display("%0t: value mismatch, expected %h actual %h", $time,
                   expected_values[0], out_ch.value);
          errors++;
        end
        void'(expected_values.pop_front());
      end
    end
  end

  // receiver stalls
  initial begin
    int stall;
    out_ch.ready = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ch.ready <= 0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  task automatic send_item(op_t op, logic [63:0] lo, logic [63:0] hi, bit gaps = 1);
    int gap;
    gap = (!gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.op <= op;
    in_ch.range_min <= lo;
    in_ch.range_max <= hi;
    do @(posedge clk); while (!in_ch.ready);
    expected_values.push_back(predict_value(op, lo, hi));
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (expected_values.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_seed(logic [63:0] s);
    drain();
    seed_value_we <= 1;
    seed_value <= s;
    @(posedge clk);
    seed_value_we <= 0;
    seed_reg = s;
  endtask

  task automatic test_unseeded_draw();
    // first draw after reset seeds from the reset seed register
    send_item(OP_RAW64, $urandom(), $urandom());
    send_item(OP_HI32, 64'd0, 64'd0);
    drain();
  endtask

  task automatic test_directed_ops();
    write_seed(64'hffffffffffffffff);
    send_item(OP_RESEED, 64'hffffffffffffffff, 64'd0);
    send_item(OP_RAW64, 64'd0, 64'hffffffffffffffff);
    send_item(OP_HI32, S64_MIN, S64_MAX);
    send_item(OP_RANGE, 64'd5, 64'd5);
    send_item(OP_RANGE, 64'd0, 64'd1);
    send_item(OP_RANGE, 64'd100, 64'd10);
    send_item(OP_RANGE, S64_MIN, S64_MAX);
    send_item(OP_RANGE, S64_MAX, S64_MIN);
    send_item(OP_RANGE, S64_MIN, S64_MIN);
    send_item(OP_RANGE, S64_MAX, S64_MAX);
    send_item(OP_RANGE, 64'hffffffffffffffff, 64'd0);
    send_item(OP_RANGE, S64_MIN, 64'd0);
    send_item(OP_RANGE, S64_MIN + 64'd1, S64_MAX);
    send_item(OP_RANGE, 64'hfffffffffffffff6, 64'd9);
    write_seed(64'd0);
    send_item(OP_RESEED, 64'd0, 64'd0);
    send_item(OP_RAW64, 64'd0, 64'd0);
    send_item(OP_RANGE, 64'd0, 64'd6);
    drain();
  endtask

  function automatic logic [63:0] rand_bound();
    case ($urandom_range(0, 5))
      0: return {$urandom(), $urandom()};
      1: return 64'($signed($urandom_range(0, 40)) - 20);
      2: return S64_MIN + 64'($urandom_range(0, 3));
      3: return S64_MAX - 64'($urandom_range(0, 3));
      default: return {{32{$urandom_range(0, 1) == 1}}, $urandom()};
    endcase
  endfunction

  task automatic test_random_mix(int count);
    op_t op;
    int pick;
    logic [63:0] lo;
    logic [63:0] hi;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) op = OP_RESEED;
      else if (pick < 30) op = OP_RAW64;
      else if (pick < 50) op = OP_HI32;
      else op = OP_RANGE;
      lo = rand_bound();
      hi = ($urandom_range(0, 2) == 0) ? lo + 64'($urandom_range(0, 1000)) : rand_bound();
      send_item(op, lo, hi, (i % 200) >= 40);
      if (i == count / 2) drain();
    end
  endtask

  initial begin
    rst = 1;
    seed_value_we = 0;
    seed_value = 0;
    in_ch.valid = 0;
    in_ch.op = OP_RESEED;
    in_ch.range_min = 0;
    in_ch.range_max = 0;
    seed_reg = 0;
    for (int i = 0; i < 4; i++) gen_words[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    test_unseeded_draw();
    test_directed_ops();
    write_seed({$urandom(), $urandom()});
    test_random_mix(600);
    write_seed(64'hffffffffffffffff);
    test_random_mix(400);
    write_seed({$urandom(), $urandom()});
    test_random_mix(800);
    drain();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
